FILE: sv/brf_pkg.sv
`timescale 1ns / 1ps
// Package for the byte ring FIFO: request codes, microcode word layout,
// the microcode program ROM and the hex character helper. No dependencies.
package brf_pkg;

  typedef enum logic [3:0] {
    OP_PUT_BYTE  = 4'd0,
    OP_PUT_U16   = 4'd1,
    OP_PUT_U32   = 4'd2,
    OP_PUT_HEX8  = 4'd3,
    OP_PUT_HEX16 = 4'd4,
    OP_GET_BYTE  = 4'd5,
    OP_GET_U16   = 4'd6,
    OP_GET_U32   = 4'd7,
    OP_STATUS    = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    UK_PUSH = 2'd0,
    UK_POP  = 2'd1,
    UK_STAT = 2'd2,
    UK_BAD  = 2'd3
  } uk_t;

  typedef enum logic [1:0] {
    SEL_RAW = 2'd0,
    SEL_HI  = 2'd1,
    SEL_LO  = 2'd2
  } sel_t;

  typedef struct packed {
    uk_t        kind;
    sel_t       sel;
    logic [1:0] lane;
    logic       upd_ok;
    logic       stop_fail;
    logic       last;
  } ucw_t;

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_LAST = 5'd21;
  localparam logic [PC_W-1:0] PC_BAD  = 5'd21;

  function automatic logic [PC_W-1:0] entry_pc(input logic [3:0] op);
    logic [PC_W-1:0] pc;
    unique case (op)
      OP_PUT_BYTE:  pc = 5'd0;
      OP_PUT_U16:   pc = 5'd1;
      OP_PUT_U32:   pc = 5'd3;
      OP_PUT_HEX8:  pc = 5'd7;
      OP_PUT_HEX16: pc = 5'd9;
      OP_GET_BYTE:  pc = 5'd13;
      OP_GET_U16:   pc = 5'd14;
      OP_GET_U32:   pc = 5'd16;
      OP_STATUS:    pc = 5'd20;
      default:      pc = PC_BAD;
    endcase
    return pc;
  endfunction

  // Fields: kind, byte source, lane, update ok, stop on failure, last step.
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    unique case (pc)
      5'd0:    w = '{UK_PUSH, SEL_RAW, 2'd0, 1'b1, 1'b1, 1'b1};
      5'd1:    w = '{UK_PUSH, SEL_RAW, 2'd1, 1'b1, 1'b1, 1'b0};
      5'd2:    w = '{UK_PUSH, SEL_RAW, 2'd0, 1'b1, 1'b1, 1'b1};
      5'd3:    w = '{UK_PUSH, SEL_RAW, 2'd3, 1'b1, 1'b1, 1'b0};
      5'd4:    w = '{UK_PUSH, SEL_RAW, 2'd2, 1'b1, 1'b1, 1'b0};
      5'd5:    w = '{UK_PUSH, SEL_RAW, 2'd1, 1'b1, 1'b1, 1'b0};
      5'd6:    w = '{UK_PUSH, SEL_RAW, 2'd0, 1'b1, 1'b1, 1'b1};
      5'd7:    w = '{UK_PUSH, SEL_HI,  2'd0, 1'b0, 1'b0, 1'b0};
      5'd8:    w = '{UK_PUSH, SEL_LO,  2'd0, 1'b1, 1'b0, 1'b1};
      5'd9:    w = '{UK_PUSH, SEL_HI,  2'd1, 1'b0, 1'b0, 1'b0};
      5'd10:   w = '{UK_PUSH, SEL_LO,  2'd1, 1'b0, 1'b0, 1'b0};
      5'd11:   w = '{UK_PUSH, SEL_HI,  2'd0, 1'b0, 1'b0, 1'b0};
      5'd12:   w = '{UK_PUSH, SEL_LO,  2'd0, 1'b1, 1'b0, 1'b1};
      5'd13:   w = '{UK_POP,  SEL_RAW, 2'd0, 1'b1, 1'b1, 1'b1};
      5'd14:   w = '{UK_POP,  SEL_RAW, 2'd0, 1'b1, 1'b1, 1'b0};
      5'd15:   w = '{UK_POP,  SEL_RAW, 2'd0, 1'b1, 1'b1, 1'b1};
      5'd16:   w = '{UK_POP,  SEL_RAW, 2'd0, 1'b1, 1'b1, 1'b0};
      5'd17:   w = '{UK_POP,  SEL_RAW, 2'd0, 1'b1, 1'b1, 1'b0};
      5'd18:   w = '{UK_POP,  SEL_RAW, 2'd0, 1'b1, 1'b1, 1'b0};
      5'd19:   w = '{UK_POP,  SEL_RAW, 2'd0, 1'b1, 1'b1, 1'b1};
      5'd20:   w = '{UK_STAT, SEL_RAW, 2'd0, 1'b1, 1'b1, 1'b1};
      default: w = '{UK_BAD,  SEL_RAW, 2'd0, 1'b1, 1'b1, 1'b1};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib > 4'd9) begin
      c = {4'd0, nib} + 8'd55;
    end else begin
      c = {4'd0, nib} + 8'd48;
    end
    return c;
  endfunction

endpackage

FILE: sv/brf_req_if.sv
`timescale 1ns / 1ps
// Request channel of the byte ring FIFO: valid/ready with opcode and data.
// Standalone; no package dependency.
interface brf_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [31:0] write_value;

  modport source (output valid, output opcode, output write_value, input ready);
  modport sink (input valid, input opcode, input write_value, output ready);
endinterface

FILE: sv/brf_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the byte ring FIFO: valid/ready with status and data.
// Standalone; no package dependency.
interface brf_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] read_value;
  logic [7:0]  fill_count;
  logic        is_full;
  logic        is_empty;

  modport source (output valid, output ok, output read_value, output fill_count,
                  output is_full, output is_empty, input ready);
  modport sink (input valid, input ok, input read_value, input fill_count,
                input is_full, input is_empty, output ready);
endinterface

FILE: sv/byte_ring_fifo_with_word_and_hex_ops_core.sv
`timescale 1ns / 1ps
// Byte ring FIFO with word and hex operations, microcoded control.
// Depends on brf_pkg, brf_req_if and brf_rsp_if.
//
// Usage: each request on req carries an opcode and a 32-bit write value and
// produces exactly one response on rsp with ok, read data, fill count and
// the full and empty flags as they stand after the request. cfg_we with
// cfg_data sets the ring size; write it only while no request is in flight.
// Each request runs a short microprogram, one store byte per step through a
// single-port byte store, then one finishing step. A request is accepted,
// then runs 1 to 4 program steps (4 for 32-bit words and hex 16-bit writes,
// fewer when a word operation stops early) and its finishing step registers
// the response. One request is in work at a time; a new one is accepted
// while the previous response still waits.
// A stalled rsp holds its response and the finishing step waits for it.
// Reset clears both indices, sets the ring size to its maximum and drops
// any pending response; store contents are left as they are.
module byte_ring_fifo_with_word_and_hex_ops_core #(
  parameter int DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [8:0] cfg_data,
  brf_req_if.sink    req,
  brf_rsp_if.source  rsp
);
  import brf_pkg::*;

  localparam int MEM_DEPTH = (DEPTH < 256) ? DEPTH : 256;
  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [8:0] MAX_SIZE = 9'(MEM_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_t;

  state_t          state;
  logic [PC_W-1:0] pc;
  logic [7:0]      wi;
  logic [7:0]      ri;
  logic [8:0]      act;
  logic [31:0]     wv;
  logic [31:0]     acc;
  logic [31:0]     acc_next;
  logic            ok_r;
  logic            pop_cap;
  logic [7:0]      mem [MEM_DEPTH];
  logic [7:0]      rdata;

  ucw_t       cw;
  logic [7:0] lane_byte;
  logic [7:0] push_data;
  logic       full_now;
  logic       empty_now;
  logic       step_ok;
  logic       mem_we;
  logic [7:0] maddr;
  logic [8:0] cnt;
  logic [8:0] wi_inc;
  logic [8:0] ri_inc;
  logic       out_free;

  assign cw        = ucode(pc);
  assign lane_byte = wv[8*cw.lane +: 8];
  assign full_now  = (({1'b0, wi} + 9'd1) == {1'b0, ri})
                     || (ri == 8'd0 && {1'b0, wi} == (act - 9'd1));
  assign empty_now = (wi == ri);
  assign wi_inc    = {1'b0, wi} + 9'd1;
  assign ri_inc    = {1'b0, ri} + 9'd1;
  assign cnt       = (wi >= ri) ? ({1'b0, wi} - {1'b0, ri})
                                : (act - {1'b0, ri} + {1'b0, wi});
  assign acc_next  = pop_cap ? {acc[23:0], rdata} : acc;
  assign out_free  = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  always_comb begin
    case (cw.sel)
      SEL_HI:  push_data = hex_char(lane_byte[7:4]);
      SEL_LO:  push_data = hex_char(lane_byte[3:0]);
      default: push_data = lane_byte;
    endcase
  end

  always_comb begin
    unique case (cw.kind)
      UK_PUSH: step_ok = !full_now;
      UK_POP:  step_ok = !empty_now;
      UK_STAT: step_ok = 1'b1;
      default: step_ok = 1'b0;
    endcase
  end

  assign mem_we = (state == S_RUN) && (cw.kind == UK_PUSH) && !full_now;
  assign maddr  = (cw.kind == UK_PUSH) ? wi : ri;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[maddr[AW-1:0]] <= push_data;
    end
    rdata <= mem[maddr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      wi        <= '0;
      ri        <= '0;
      act       <= MAX_SIZE;
      pop_cap   <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_data < 9'd2) begin
          act <= 9'd2;
        end else if (cfg_data > MAX_SIZE) begin
          act <= MAX_SIZE;
        end else begin
          act <= cfg_data;
        end
      end
      if (rsp.valid && rsp.ready && state != S_FIN) begin
        rsp.valid <= 1'b0;
      end
      pop_cap <= (state == S_RUN) && (cw.kind == UK_POP) && step_ok;
      if (pop_cap) begin
        acc <= acc_next;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            pc    <= entry_pc(req.opcode);
            wv    <= req.write_value;
            acc   <= '0;
            ok_r  <= 1'b0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (cw.kind == UK_PUSH && step_ok) begin
            wi <= (wi_inc >= act) ? 8'd0 : wi_inc[7:0];
          end
          if (cw.kind == UK_POP && step_ok) begin
            ri <= (ri_inc >= act) ? 8'd0 : ri_inc[7:0];
          end
          if (cw.upd_ok) begin
            ok_r <= step_ok;
          end
          if (cw.last || (cw.stop_fail && !step_ok)) begin
            state <= S_FIN;
          end else begin
            pc <= pc + 1'b1;
          end
        end
        S_FIN: begin
          if (out_free) begin
            rsp.valid      <= 1'b1;
            rsp.ok         <= ok_r;
            rsp.read_value <= ok_r ? acc_next : 32'd0;
            rsp.fill_count <= cnt[7:0];
            rsp.is_full    <= full_now;
            rsp.is_empty   <= empty_now;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ok |-> rsp.read_value == 32'd0)
    else $error("failed request returned data");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.is_full && rsp.is_empty))
    else $error("full and empty reported together");

  a_pc_in_rom: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> pc <= PC_LAST)
    else $error("microcode step counter out of program");

  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == S_RUN)
    else $error("accepted request did not start its program");

endmodule
